### rtl/pcpa_pkg.sv
// ----------------------------------------------------------------------------
// pcpa_pkg
// Shared types and codes for the per-CPU page allocator.
// ----------------------------------------------------------------------------
package pcpa_pkg;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_FREED     = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_BAD_FREE  = 2'd3
    } t_status;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic REG_LOW_LIMIT  = 1'b0;
    localparam logic REG_HIGH_LIMIT = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  cpu;
        logic [31:0] page_addr;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] alloc_addr;
        logic        stolen;
    } t_rsp;

    typedef struct packed {
        logic        index;
        logic [31:0] data;
    } t_cfg;

endpackage

### rtl/pcpa_if.sv
// ----------------------------------------------------------------------------
// pcpa_req_if / pcpa_rsp_if / pcpa_cfg_if
// Valid/ready channels of the page allocator.
// ----------------------------------------------------------------------------
interface pcpa_req_if;
    logic           valid;
    logic           ready;
    pcpa_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pcpa_rsp_if;
    logic           valid;
    logic           ready;
    pcpa_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pcpa_cfg_if;
    logic           valid;
    logic           ready;
    pcpa_pkg::t_cfg payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/pcpa_ram.sv
// ----------------------------------------------------------------------------
// pcpa_ram
// Single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module pcpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### rtl/per_cpu_page_allocator_steal.sv
// ----------------------------------------------------------------------------
// per_cpu_page_allocator_steal
// Per-CPU LIFO free lists of 4 KiB pages, linked through a next-link RAM,
// with round-robin stealing of half a list when the requester runs dry.
// ----------------------------------------------------------------------------
// channel   dir  signals                     transaction
// i_req     in   valid/ready, t_req          one alloc or free request
// o_rsp     out  valid/ready, t_rsp          one result per request
// i_cfg     in   valid/ready, t_cfg          write low_limit / high_limit
//
// Free: check and link write at acceptance. Alloc from own list: link read
// issue (S_POP_RD), then data and update (S_POP_WAIT). Steal: scan of up to
// NCPU-1 heads one per cycle (the head read of the victim goes out in its scan
// cycle), S_FIRST_WAIT for the first link, then ceil(n/2)-1 dependent link
// reads, each through S_WALK_RD and S_WALK_WAIT on the single RAM port; that
// walk dominates. No page anywhere: the scan ends in an ST_EMPTY result.
// Reset is synchronous, active low; it empties every list (counts to zero).
// The link RAM needs no clearing: only written entries are read.
// A result waits in the output register; the next request is accepted once
// the response transaction has gone.
// ----------------------------------------------------------------------------
module per_cpu_page_allocator_steal #(
    parameter int NCPU   = 8,
    parameter int NPAGES = 32768
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcpa_req_if.sink   i_req,
    pcpa_rsp_if.source o_rsp,
    pcpa_cfg_if.sink   i_cfg
);
    import pcpa_pkg::*;

    localparam int PW = (NPAGES > 1) ? $clog2(NPAGES) : 1;  // page index width
    localparam int CW = (NCPU > 1) ? $clog2(NCPU) : 1;
    localparam int NW = PW + 7;                            // list count width (wraps harmlessly)

    typedef enum logic [2:0] {
        S_IDLE, S_POP_RD, S_POP_WAIT, S_SCAN, S_WALK_RD, S_WALK_WAIT, S_FIRST_WAIT, S_RESP
    } t_state;

    t_state        r_state;
    logic [31:0]   r_low, r_high;
    logic [PW-1:0] r_head [NCPU];
    logic [NW-1:0] r_cnt  [NCPU];

    logic [CW-1:0] r_cpu, r_vic;
    logic [CW:0]   r_tries;
    logic [PW-1:0] r_first, r_last;
    logic [NW-1:0] r_take, r_k;
    logic [31:0]   r_base;
    t_rsp          r_rsp;
    logic          r_rsp_v;

    // link RAM port
    logic          ram_we;
    logic [PW-1:0] ram_addr, ram_wdata, ram_rdata;

    pcpa_ram #(.WIDTH(PW), .DEPTH(NPAGES)) u_link (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // free check on the input payload
    logic [32:0]   base33;
    logic [31:0]   base;
    logic [32:0]   off;
    logic          free_ok;
    logic [CW-1:0] in_cpu;
    logic [20:0]   pidx;

    assign base33 = ({1'b0, r_low} + 33'hFFF) & ~33'hFFF;
    assign base   = base33[31:0];
    assign off    = {1'b0, i_req.payload.page_addr} - base33;
    assign pidx   = off[32:12];
    assign in_cpu = CW'({29'd0, i_req.payload.cpu} % NCPU);
    assign free_ok = (i_req.payload.page_addr[11:0] == 12'd0)
                  && (i_req.payload.page_addr >= r_low)
                  && (i_req.payload.page_addr < r_high)
                  && !off[32]
                  && ({11'd0, pidx} < 32'(NPAGES));

    logic accept;
    assign i_req.ready = (r_state == S_IDLE) && !r_rsp_v;
    assign accept      = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid   = r_rsp_v;
    assign o_rsp.payload = r_rsp;

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_last;
        ram_wdata = r_head[in_cpu];
        if (accept && i_req.payload.req_type == REQ_FREE) begin
            ram_we    = free_ok;
            ram_addr  = PW'(pidx);
            ram_wdata = (r_cnt[in_cpu] != '0) ? r_head[in_cpu] : '0;
        end else if (r_state == S_POP_RD) begin
            ram_addr = r_head[r_cpu];
        end else if (r_state == S_SCAN) begin
            ram_addr = r_head[r_vic];
        end
    end

    logic [CW-1:0] vic_nx;
    assign vic_nx = (r_vic == CW'(NCPU - 1)) ? '0 : r_vic + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rsp_v <= 1'b0;
            r_low   <= 32'h8000_0000;
            r_high  <= 32'h8800_0000;
            for (int i = 0; i < NCPU; i++) begin
                r_cnt[i]  <= '0;
                r_head[i] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.payload.index == REG_LOW_LIMIT) r_low <= i_cfg.payload.data;
                else                                      r_high <= i_cfg.payload.data;
            end
            if (o_rsp.valid && o_rsp.ready) r_rsp_v <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cpu  <= in_cpu;
                        r_base <= base;
                        if (i_req.payload.req_type == REQ_FREE) begin
                            r_rsp_v <= 1'b1;
                            r_rsp   <= free_ok ? '{ST_FREED, 32'd0, 1'b0}
                                               : '{ST_BAD_FREE, 32'd0, 1'b0};
                            if (free_ok) begin
                                r_head[in_cpu] <= PW'(pidx);
                                r_cnt[in_cpu]  <= r_cnt[in_cpu] + 1'b1;
                            end
                        end else if (r_cnt[in_cpu] != '0) begin
                            r_state <= S_POP_RD;
                        end else begin
                            r_vic   <= (in_cpu == CW'(NCPU - 1)) ? '0 : in_cpu + 1'b1;
                            r_tries <= (CW+1)'(1);
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_POP_RD: begin
                    r_first <= r_head[r_cpu];
                    r_state <= S_POP_WAIT;
                end
                S_POP_WAIT: begin
                    r_head[r_cpu] <= ram_rdata;
                    r_cnt[r_cpu]  <= r_cnt[r_cpu] - 1'b1;
                    r_rsp   <= '{ST_ALLOCATED, r_base + {r_first, 12'd0}, 1'b0};
                    r_rsp_v <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    if (r_tries >= (CW+1)'(NCPU)) begin
                        r_rsp   <= '{ST_EMPTY, 32'd0, 1'b0};
                        r_rsp_v <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_cnt[r_vic] == '0) begin
                        r_vic   <= vic_nx;
                        r_tries <= r_tries + 1'b1;
                    end else begin
                        // head read issued this cycle; data is next of first
                        r_first <= r_head[r_vic];
                        r_last  <= r_head[r_vic];
                        r_take  <= (r_cnt[r_vic] >> 1) + NW'(r_cnt[r_vic][0]);
                        r_k     <= NW'(1);
                        r_state <= S_FIRST_WAIT;
                    end
                end
                S_FIRST_WAIT: begin
                    // ram_rdata = next of first: requester's new head, or victim's if take is 1
                    r_head[r_cpu] <= (r_take > NW'(1)) ? ram_rdata : '0;
                    r_cnt[r_cpu]  <= r_take - 1'b1;
                    if (r_take == NW'(1)) begin
                        r_head[r_vic] <= ram_rdata;
                        r_cnt[r_vic]  <= r_cnt[r_vic] - r_take;
                        r_rsp   <= '{ST_ALLOCATED, r_base + {r_first, 12'd0}, 1'b1};
                        r_rsp_v <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_last  <= ram_rdata;
                        r_k     <= NW'(2);
                        r_state <= S_WALK_RD;
                    end
                end
                S_WALK_RD: begin
                    // reads next of r_last
                    r_state <= S_WALK_WAIT;
                end
                S_WALK_WAIT: begin
                    if (r_k == r_take) begin
                        r_head[r_vic] <= ram_rdata;
                        r_cnt[r_vic]  <= r_cnt[r_vic] - r_take;
                        r_rsp   <= '{ST_ALLOCATED, r_base + {r_first, 12'd0}, 1'b1};
                        r_rsp_v <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_last  <= ram_rdata;
                        r_k     <= r_k + 1'b1;
                        r_state <= S_WALK_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
